// ----- rtl/jse_pkg.sv -----
// jse_pkg: shared types and constants of the job schedule evaluator
// used by jse_cell, jse_ctrl and job_schedule_evaluator; no dependencies
`default_nettype none

package jse_pkg;

    localparam int MAX_JOBS_DEF = 32;
    localparam int COUNT_W      = 7;
    localparam int CLOCK_W      = 23;
    localparam int WAIT_W       = 23;
    localparam int FINISH_W     = 22;
    localparam int TOTAL_W      = 29;
    localparam int IN_DATA_W    = 48;
    localparam int OUT_DATA_W   = 88;

    typedef struct packed {
        logic        valid;
        logic        done;
        logic [7:0]  id;
        logic [15:0] arrival;
        logic [15:0] service;
        logic [7:0]  urgency;
        logic [15:0] remaining;
    } jse_entry_t;

    typedef struct packed {
        logic               load_en;
        logic [COUNT_W-1:0] load_idx;
        logic               rotate;
        logic               clear;
    } jse_ring_ctrl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEL,
        ST_EMIT,
        ST_RR
    } jse_state_t;

    typedef enum logic [1:0] {
        MODE_FCFS = 2'd0,
        MODE_SJF  = 2'd1,
        MODE_PRIO = 2'd2,
        MODE_RR   = 2'd3
    } jse_mode_t;

    localparam logic CFG_MODE    = 1'b0;
    localparam logic CFG_QUANTUM = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/jse_cell.sv -----
// jse_cell: one slot of the job ring, holds one job and hands it to its neighbor
// depends on jse_pkg
`default_nettype none

module jse_cell #(
    parameter int IDX = 0
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  jse_pkg::jse_ring_ctrl_t ctrl,
    input  jse_pkg::jse_entry_t     load_entry,
    input  jse_pkg::jse_entry_t     next_entry,
    output jse_pkg::jse_entry_t     entry
);
    import jse_pkg::*;

    logic       valid_reg;
    jse_entry_t data_reg;
    logic       load_hit;

    assign load_hit = ctrl.load_en && (ctrl.load_idx == COUNT_W'(IDX));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.clear) begin
            valid_reg <= 1'b0;
        end else if (load_hit) begin
            valid_reg <= 1'b1;
        end else if (ctrl.rotate) begin
            valid_reg <= next_entry.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_hit) begin
            data_reg <= load_entry;
        end else if (ctrl.rotate) begin
            data_reg <= next_entry;
        end
    end

    always_comb begin
        entry       = data_reg;
        entry.valid = valid_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/jse_ctrl.sv -----
// jse_ctrl: load sequencer, selection and round robin engine, result register
// depends on jse_pkg; drives the ring of jse_cell slots
`default_nettype none

module jse_ctrl #(
    parameter int MAX_JOBS = jse_pkg::MAX_JOBS_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [jse_pkg::IN_DATA_W-1:0]     s_tdata,
    input  wire                               s_tlast,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [jse_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire                               cfg_index,
    input  wire  [15:0]                       cfg_data,
    input  jse_pkg::jse_entry_t               head_entry,
    output jse_pkg::jse_entry_t               head_mod,
    output jse_pkg::jse_entry_t               load_entry,
    output jse_pkg::jse_ring_ctrl_t           ring_ctrl
);
    import jse_pkg::*;

    localparam int IDXW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

    jse_state_t         state_reg, state_next;
    logic [1:0]         mode_reg;
    logic [15:0]        quantum_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] emitted_reg, emitted_next;
    logic [IDXW-1:0]    step_reg, step_next;
    logic [CLOCK_W-1:0] clock_reg, clock_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               have_best_reg, have_best_next;
    logic [7:0]         best_id_reg, best_id_next;
    logic [15:0]        best_svc_reg, best_svc_next;
    logic [7:0]         best_urg_reg, best_urg_next;
    logic [IDXW-1:0]    best_pos_reg, best_pos_next;
    logic               prev_valid_reg, prev_valid_next;
    logic [IDXW-1:0]    prev_pos_reg, prev_pos_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_id_reg, out_id_next;
    logic [WAIT_W-1:0]  out_wait_reg, out_wait_next;
    logic [FINISH_W-1:0] out_finish_reg, out_finish_next;
    logic [TOTAL_W-1:0] out_total_reg, out_total_next;
    logic               out_last_reg, out_last_next;

    jse_entry_t         h;
    logic               out_free, in_acc, step_last, rec_last, table_room;
    logic               cand, better;
    logic [15:0]        q, slice, rem_left, in_svc;
    logic               rr_active, rr_fin;
    logic [CLOCK_W-1:0] rr_clock, sel_clock;
    logic [CLOCK_W:0]   rr_wait_ext;
    logic [WAIT_W-1:0]  rr_wait;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_LOAD);
    assign m_tvalid  = out_valid_reg;
    assign m_tlast   = out_last_reg;
    assign m_tdata   = {6'b0, out_total_reg, out_finish_reg, out_wait_reg, out_id_reg};

    // shared datapath terms
    always_comb begin
        out_free   = !out_valid_reg || m_tready;
        in_acc     = s_tvalid && (state_reg == ST_LOAD);
        table_room = count_reg < COUNT_W'(MAX_JOBS);
        step_last  = step_reg == IDXW'(MAX_JOBS - 1);
        rec_last   = (emitted_reg + COUNT_W'(1)) == count_reg;

        in_svc = (s_tdata[39:24] == 16'd0) ? 16'd1 : s_tdata[39:24];
        load_entry.valid     = 1'b1;
        load_entry.done      = 1'b0;
        load_entry.id        = s_tdata[7:0];
        load_entry.arrival   = s_tdata[23:8];
        load_entry.service   = in_svc;
        load_entry.urgency   = s_tdata[47:40];
        load_entry.remaining = in_svc;

        // the job emitted last round gets its done mark as it passes the head
        h = head_entry;
        if (state_reg == ST_SEL && prev_valid_reg && step_reg == prev_pos_reg) begin
            h.done = 1'b1;
        end

        cand   = h.valid && !h.done;
        better = !have_best_reg
              || (mode_reg == MODE_SJF  && h.service < best_svc_reg)
              || (mode_reg == MODE_PRIO && h.urgency > best_urg_reg);

        q         = (quantum_reg == 16'd0) ? 16'd1 : quantum_reg;
        slice     = (h.remaining < q) ? h.remaining : q;
        rem_left  = h.remaining - slice;
        rr_active = h.valid && (h.remaining != 16'd0);
        rr_fin    = rr_active && (rem_left == 16'd0);
        rr_clock  = clock_reg + {7'b0, slice};
        rr_wait_ext = {1'b0, rr_clock} - {8'b0, h.arrival} - {8'b0, h.service};
        rr_wait   = rr_wait_ext[WAIT_W-1:0];
        sel_clock = clock_reg + {7'b0, best_svc_reg};
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (in_acc && s_tlast) begin
                    state_next = (mode_reg == MODE_RR) ? ST_RR : ST_SEL;
                end
            end
            ST_SEL: begin
                if (step_last) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) state_next = rec_last ? ST_LOAD : ST_SEL;
            end
            ST_RR: begin
                if (out_free && rr_fin && rec_last) state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // datapath and ring control
    always_comb begin
        count_next      = count_reg;
        emitted_next    = emitted_reg;
        step_next       = step_reg;
        clock_next      = clock_reg;
        total_next      = total_reg;
        have_best_next  = have_best_reg;
        best_id_next    = best_id_reg;
        best_svc_next   = best_svc_reg;
        best_urg_next   = best_urg_reg;
        best_pos_next   = best_pos_reg;
        prev_valid_next = prev_valid_reg;
        prev_pos_next   = prev_pos_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_id_next     = out_id_reg;
        out_wait_next   = out_wait_reg;
        out_finish_next = out_finish_reg;
        out_total_next  = out_total_reg;
        out_last_next   = out_last_reg;
        head_mod        = h;
        ring_ctrl.load_en  = 1'b0;
        ring_ctrl.load_idx = count_reg;
        ring_ctrl.rotate   = 1'b0;
        ring_ctrl.clear    = 1'b0;

        unique case (state_reg)
            ST_LOAD: begin
                if (in_acc) begin
                    if (table_room) begin
                        ring_ctrl.load_en = 1'b1;
                        count_next = count_reg + COUNT_W'(1);
                    end
                    if (s_tlast) begin
                        clock_next      = '0;
                        total_next      = '0;
                        emitted_next    = '0;
                        step_next       = '0;
                        have_best_next  = 1'b0;
                        prev_valid_next = 1'b0;
                    end
                end
            end
            ST_SEL: begin
                ring_ctrl.rotate = 1'b1;
                step_next = step_last ? '0 : step_reg + IDXW'(1);
                if (cand && better) begin
                    have_best_next = 1'b1;
                    best_id_next   = h.id;
                    best_svc_next  = h.service;
                    best_urg_next  = h.urgency;
                    best_pos_next  = step_reg;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_id_next     = best_id_reg;
                    out_wait_next   = clock_reg;
                    out_finish_next = sel_clock[FINISH_W-1:0];
                    out_total_next  = total_reg + {6'b0, clock_reg};
                    out_last_next   = rec_last;
                    total_next      = total_reg + {6'b0, clock_reg};
                    clock_next      = sel_clock;
                    emitted_next    = emitted_reg + COUNT_W'(1);
                    prev_valid_next = 1'b1;
                    prev_pos_next   = best_pos_reg;
                    have_best_next  = 1'b0;
                    if (rec_last) begin
                        ring_ctrl.clear = 1'b1;
                        count_next      = '0;
                    end
                end
            end
            ST_RR: begin
                if (out_free) begin
                    ring_ctrl.rotate = 1'b1;
                    if (rr_active) begin
                        head_mod.remaining = rem_left;
                        clock_next = rr_clock;
                    end
                    if (rr_fin) begin
                        out_valid_next  = 1'b1;
                        out_id_next     = h.id;
                        out_wait_next   = rr_wait;
                        out_finish_next = rr_clock[FINISH_W-1:0];
                        out_total_next  = total_reg + {{6{rr_wait[WAIT_W-1]}}, rr_wait};
                        out_last_next   = rec_last;
                        total_next      = total_reg + {{6{rr_wait[WAIT_W-1]}}, rr_wait};
                        emitted_next    = emitted_reg + COUNT_W'(1);
                        if (rec_last) begin
                            ring_ctrl.clear = 1'b1;
                            count_next      = '0;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            mode_reg       <= MODE_FCFS;
            quantum_reg    <= 16'd10;
            count_reg      <= '0;
            emitted_reg    <= '0;
            step_reg       <= '0;
            clock_reg      <= '0;
            total_reg      <= '0;
            have_best_reg  <= 1'b0;
            prev_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            emitted_reg    <= emitted_next;
            step_reg       <= step_next;
            clock_reg      <= clock_next;
            total_reg      <= total_next;
            have_best_reg  <= have_best_next;
            prev_valid_reg <= prev_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_MODE:    mode_reg    <= cfg_data[1:0];
                    CFG_QUANTUM: quantum_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        best_id_reg    <= best_id_next;
        best_svc_reg   <= best_svc_next;
        best_urg_reg   <= best_urg_next;
        best_pos_reg   <= best_pos_next;
        prev_pos_reg   <= prev_pos_next;
        out_id_reg     <= out_id_next;
        out_wait_reg   <= out_wait_next;
        out_finish_reg <= out_finish_next;
        out_total_reg  <= out_total_next;
        out_last_reg   <= out_last_next;
    end

endmodule

`default_nettype wire

// ----- rtl/job_schedule_evaluator.sv -----
// job_schedule_evaluator: batch job scheduler, top level
// depends on jse_pkg, jse_cell and jse_ctrl
//
// usage:
//   jobs arrive on the s_ stream, one per transaction; tlast marks the final
//   job of a set and starts scheduling. up to MAX_JOBS jobs are kept, extra
//   jobs are dropped. s_tready is high only while the block is loading.
//   results leave on the m_ stream in completion order, tlast on the last
//   record of the set. the cfg write channel sets mode (index 0) and quantum
//   (index 1); it is always ready and may be written only while idle.
// timing:
//   in the ordered modes the ring of cells rotates once around all MAX_JOBS
//   slots per record, then the record is emitted. in round robin one slot
//   passes the head per cycle while the result register is free, until every
//   job is finished.
// reset clears the job count, mode to first come, quantum to 10.
// a stalled m_ side halts emit and round robin until the result register drains.
`default_nettype none

module job_schedule_evaluator #(
    parameter int MAX_JOBS = jse_pkg::MAX_JOBS_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // job_id[7:0], arrival[23:8], service[39:24], urgency[47:40]
    input  wire  [jse_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire                            s_tlast,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // done_id[7:0], wait_time[30:8], finish_time[52:31], wait_total[81:53], zero
    output logic [jse_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire                            cfg_index,
    input  wire  [15:0]                    cfg_data
);
    import jse_pkg::*;

    jse_entry_t     ring [MAX_JOBS];
    jse_entry_t     head_mod;
    jse_entry_t     load_entry;
    jse_ring_ctrl_t ring_ctrl;

    jse_ctrl #(
        .MAX_JOBS(MAX_JOBS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head_entry (ring[0]),
        .head_mod   (head_mod),
        .load_entry (load_entry),
        .ring_ctrl  (ring_ctrl)
    );

    // slot i takes slot i+1 on rotate, the tail takes the updated head
    for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
        jse_entry_t next_entry;
        if (i == MAX_JOBS - 1) begin : g_tail
            assign next_entry = head_mod;
        end else begin : g_mid
            assign next_entry = ring[i+1];
        end
        jse_cell #(
            .IDX(i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ring_ctrl),
            .load_entry (load_entry),
            .next_entry (next_entry),
            .entry      (ring[i])
        );
    end

endmodule

`default_nettype wire
